[rtl/uws_pkg.sv]
// Shared constants, types and ending table for the unknown word signature block.
package uws_pkg;

  localparam logic [2:0] LEN_SAT   = 3'd5;
  localparam logic [1:0] UPPER_SAT = 2'd2;
  localparam int         N_END3    = 17;

  localparam logic [7:0] CH_UP_A  = "A";
  localparam logic [7:0] CH_UP_Z  = "Z";
  localparam logic [7:0] CH_LO_A  = "a";
  localparam logic [7:0] CH_LO_Z  = "z";
  localparam logic [7:0] CH_DIG_0 = "0";
  localparam logic [7:0] CH_DIG_9 = "9";
  localparam logic [7:0] CH_DASH  = "-";
  localparam logic [7:0] CH_CASE  = 8'd32;
  localparam logic [7:0] CH_S     = "s";
  localparam logic [7:0] CH_I     = "i";
  localparam logic [7:0] CH_U     = "u";
  localparam logic [7:0] CH_L     = "l";
  localparam logic [7:0] CH_Y     = "y";
  localparam logic [7:0] CH_E     = "e";
  localparam logic [7:0] CH_D     = "d";
  localparam logic [7:0] CH_N     = "n";
  localparam logic [7:0] CH_G     = "g";

  localparam logic [23:0] ENDINGS3 [N_END3] = '{
    "ing", "ted", "ika", "lly", "est", "ned", "ink", "ded", "nik",
    "rma", "ely", "sly", "gly", "nly", "ify", "ier", "tly"
  };

  localparam logic [2:0] CAP_NONE       = 3'd0;
  localparam logic [2:0] CAP_INIT       = 3'd1;
  localparam logic [2:0] CAP_INIT_KNOWN = 3'd2;
  localparam logic [2:0] CAP_CAPS       = 3'd3;
  localparam logic [2:0] CAP_LOWER      = 3'd4;

  localparam logic [4:0] SUF_NONE     = 5'd0;
  localparam logic [4:0] SUF_PLURAL   = 5'd1;
  localparam logic [4:0] SUF_END_BASE = 5'd2;
  localparam logic [4:0] SUF_LY       = 5'd19;
  localparam logic [4:0] SUF_ED       = 5'd20;
  localparam logic [4:0] SUF_NG       = 5'd21;
  localparam logic [4:0] SUF_D        = 5'd22;
  localparam logic [4:0] SUF_G        = 5'd23;

  typedef struct packed {
    logic [2:0]      len;
    logic [1:0]      upper;
    logic            dash;
    logic            digit;
    logic [2:0][7:0] tail;
  } word_sum_t;

endpackage

[rtl/uws_suffix.sv]
// Suffix code from the closing summary of a word.
module uws_suffix (
  input  uws_pkg::word_sum_t sum,
  output logic [4:0]         suffix_code
);
  import uws_pkg::*;

  logic [7:0] a, b, c;
  logic       found;

  assign a = sum.tail[0];
  assign b = sum.tail[1];
  assign c = sum.tail[2];

  always_comb begin
    suffix_code = SUF_NONE;
    found       = 1'b0;
    if (sum.len >= 3'd3 && c == CH_S) begin
      suffix_code = (b == CH_S || b == CH_I || b == CH_U) ? SUF_NONE : SUF_PLURAL;
    end else if (sum.len >= LEN_SAT && !sum.dash && !(sum.digit && sum.upper != 2'd0)) begin
      for (int i = 0; i < N_END3; i++) begin
        if (!found && {a, b, c} == ENDINGS3[i]) begin
          suffix_code = SUF_END_BASE + 5'(i);
          found       = 1'b1;
        end
      end
      if (!found) begin
        if (b == CH_L && c == CH_Y) begin
          suffix_code = SUF_LY;
        end else if (b == CH_E && c == CH_D) begin
          suffix_code = SUF_ED;
        end else if (b == CH_N && c == CH_G) begin
          suffix_code = SUF_NG;
        end else if (c == CH_D) begin
          suffix_code = SUF_D;
        end else if (c == CH_G) begin
          suffix_code = SUF_G;
        end
      end
    end
  end

endmodule

[rtl/unknown_word_signature.sv]
// Streams a word one character per beat and returns one signature beat per word.
// One character is taken every cycle while in_stall is low. A character is held
// in an input register and from there folded into the word's running counts; on
// the character flagged last, the signature (capitalization class, digit and dash
// flags, suffix code) is loaded into the output register, so it passes through
// the input register and then the output register. Characters that do not close
// a word keep flowing while a signature waits at the output; a closing character
// waits only while the previous signature is still stalled.
module unknown_word_signature (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_last,
  input  logic       in_sentence_start,
  input  logic       in_known_lowercase,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_cap_class,
  output logic       out_has_number,
  output logic       out_has_hyphen,
  output logic [4:0] out_suffix_code
);
  import uws_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_last_r;
  logic       s1_sstart_r;
  logic       s1_known_r;

  logic [2:0]      len_r, len_nxt;
  logic [1:0]      upper_r, upper_nxt;
  logic            first_up_r, first_up_nxt;
  logic            lower_r, lower_nxt;
  logic            digit_r, digit_nxt;
  logic            dash_r, dash_nxt;
  logic [2:0][7:0] tail_r, tail_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [2:0] cap_r, cap_nxt;
  logic       num_r;
  logic       hyph_r;
  logic [4:0] suf_r, suf_nxt;

  logic       out_free, proc, is_up;
  word_sum_t  sum;

  assign out_free = !out_valid_r || !out_stall;
  assign proc     = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !proc;

  assign is_up = s1_ch_r >= CH_UP_A && s1_ch_r <= CH_UP_Z;

  always_comb begin
    len_nxt      = (len_r < LEN_SAT) ? len_r + 3'd1 : len_r;
    upper_nxt    = (is_up && upper_r < UPPER_SAT) ? upper_r + 2'd1 : upper_r;
    first_up_nxt = (len_r == 3'd0) ? is_up : first_up_r;
    lower_nxt    = lower_r || (s1_ch_r >= CH_LO_A && s1_ch_r <= CH_LO_Z);
    digit_nxt    = digit_r || (s1_ch_r >= CH_DIG_0 && s1_ch_r <= CH_DIG_9);
    dash_nxt     = dash_r || (s1_ch_r == CH_DASH);
    tail_nxt[0]  = tail_r[1];
    tail_nxt[1]  = tail_r[2];
    tail_nxt[2]  = is_up ? s1_ch_r + CH_CASE : s1_ch_r;
  end

  always_comb begin
    if (first_up_nxt) begin
      if (s1_sstart_r && upper_nxt == 2'd1) begin
        cap_nxt = s1_known_r ? CAP_INIT_KNOWN : CAP_INIT;
      end else begin
        cap_nxt = CAP_CAPS;
      end
    end else begin
      cap_nxt = lower_nxt ? CAP_LOWER : CAP_NONE;
    end
  end

  assign sum = '{len: len_nxt, upper: upper_nxt, dash: dash_nxt, digit: digit_nxt,
                 tail: tail_nxt};

  uws_suffix u_suffix (
    .sum         (sum),
    .suffix_code (suf_nxt)
  );

  assign out_valid_nxt = out_free ? (proc && s1_last_r) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      len_r       <= '0;
      upper_r     <= '0;
      first_up_r  <= 1'b0;
      lower_r     <= 1'b0;
      digit_r     <= 1'b0;
      dash_r      <= 1'b0;
      tail_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (proc) begin
        if (s1_last_r) begin
          len_r      <= '0;
          upper_r    <= '0;
          first_up_r <= 1'b0;
          lower_r    <= 1'b0;
          digit_r    <= 1'b0;
          dash_r     <= 1'b0;
          tail_r     <= '0;
        end else begin
          len_r      <= len_nxt;
          upper_r    <= upper_nxt;
          first_up_r <= first_up_nxt;
          lower_r    <= lower_nxt;
          digit_r    <= digit_nxt;
          dash_r     <= dash_nxt;
          tail_r     <= tail_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_ch_r     <= in_ch;
      s1_last_r   <= in_last;
      s1_sstart_r <= in_sentence_start;
      s1_known_r  <= in_known_lowercase;
    end
    if (out_free && proc && s1_last_r) begin
      cap_r  <= cap_nxt;
      num_r  <= digit_nxt;
      hyph_r <= dash_nxt;
      suf_r  <= suf_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cap_class   = cap_r;
  assign out_has_number  = num_r;
  assign out_has_hyphen  = hyph_r;
  assign out_suffix_code = suf_r;

  a_close_emits: assert property (@(posedge clk) disable iff (!rst_n)
    proc && s1_last_r |=> out_valid)
    else $error("closing character did not produce a signature");

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    proc && s1_last_r |=> len_r == 3'd0 && upper_r == 2'd0)
    else $error("word state not cleared after closing character");

  a_hyphen_suffix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_hyphen |->
      out_suffix_code == SUF_NONE || out_suffix_code == SUF_PLURAL)
    else $error("ending suffix given for a hyphenated word");

endmodule
